>>> hdl/cle_pkg.sv
// Shared types and constants of the console line editor.
package cle_pkg;

  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] KEY_LBRK  = 8'h5B;
  localparam logic [7:0] KEY_C     = 8'h43;
  localparam logic [7:0] KEY_D     = 8'h44;
  localparam logic [7:0] KEY_NUL   = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DELETE,
    OP_ENTER,
    OP_RIGHT,
    OP_LEFT
  } cle_op_e;

  typedef struct packed {
    cle_op_e    op;
    logic [7:0] key;
  } cle_cmd_t;

endpackage

>>> hdl/console_line_editor.sv
// Top level of the console line editor: front end, command queue and engine.
//
// The block takes one keyboard byte per input transaction on key_byte_i
// (in_valid_i / in_stall_o) and produces output transactions on out_byte_o,
// channel_o and last_o (out_valid_o / out_stall_i). channel_o is 0 for echo
// bytes meant for the terminal and 1 for bytes of a completed line, which
// end with a zero byte. last_o marks the final output of a key; keys that
// cause no output produce no transaction at all.
// The front end classifies keys and tracks escape sequences, and
// queues edit commands four deep, so typing continues while the engine works.
// The engine owns a line memory with one write port and one registered read
// port (one write and one registered read per cycle); they set the cost of an
// edit. An insert or delete first shifts the bytes right of the cursor through
// the memory and then echoes; at the end of the line there is no shift.
// Reset empties the queue, the line and the escape state. While out_stall_i
// is high the output register holds its transaction, the engine stops at its
// next output byte, and once the queue fills in_stall_o rises.
module console_line_editor #(
  parameter int LINE_CAP = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       channel_o,
  output logic       last_o
);
  import cle_pkg::*;

  // Commands between the front end and the queue, and the queue and engine.
  cle_cmd_t push_cmd;
  cle_cmd_t pop_cmd;
  logic     push;
  logic     queue_full;
  logic     pop;
  logic     queue_empty;

  cle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .key_byte_i (key_byte_i),
    .full_i     (queue_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  cle_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (queue_empty)
  );

  // The engine pops one command at a time and runs it to its last byte.
  cle_back #(
    .LINE_CAP (LINE_CAP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (queue_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .channel_o   (channel_o),
    .last_o      (last_o)
  );

endmodule

>>> hdl/cle_front.sv
// Front end: takes key bytes, tracks escape sequences and emits edit commands.
module cle_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       key_byte_i,
  input  logic             full_i,
  output logic             push_o,
  output cle_pkg::cle_cmd_t push_cmd_o
);
  import cle_pkg::*;

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_ESC,
    PH_CSI
  } phase_e;

  phase_e phase_q, phase_d;
  logic   accept;
  logic   cmd_ok;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    phase_d         = phase_q;
    cmd_ok          = 1'b0;
    push_cmd_o.op   = OP_INSERT;
    push_cmd_o.key  = key_byte_i;
    case (phase_q)
      PH_ESC: begin
        phase_d = (key_byte_i == KEY_LBRK) ? PH_CSI : PH_NORMAL;
      end
      PH_CSI: begin
        phase_d = PH_NORMAL;
        if (key_byte_i == KEY_C) begin
          cmd_ok        = 1'b1;
          push_cmd_o.op = OP_RIGHT;
        end else if (key_byte_i == KEY_D) begin
          cmd_ok        = 1'b1;
          push_cmd_o.op = OP_LEFT;
        end
      end
      default: begin
        if (key_byte_i == KEY_CR || key_byte_i == KEY_LF) begin
          cmd_ok        = 1'b1;
          push_cmd_o.op = OP_ENTER;
        end else if (key_byte_i == KEY_BS || key_byte_i == KEY_DEL) begin
          cmd_ok        = 1'b1;
          push_cmd_o.op = OP_DELETE;
        end else if (key_byte_i == KEY_ESC) begin
          phase_d = PH_ESC;
        end else if (key_byte_i >= PRINT_LO && key_byte_i <= PRINT_HI) begin
          cmd_ok        = 1'b1;
          push_cmd_o.op = OP_INSERT;
        end
      end
    endcase
  end

  assign push_o = accept && cmd_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

>>> hdl/cle_fifo.sv
// Small command queue between the front end and the editing engine.
module cle_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cle_pkg::cle_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output cle_pkg::cle_cmd_t pop_cmd_o,
  output logic              empty_o
);
  import cle_pkg::*;

  cle_cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]       count_q;
  logic                    do_push, do_pop;

  assign full_o    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

>>> hdl/cle_back.sv
// Editing engine: line memory, cursor state and the output byte sequencer.
module cle_back #(
  parameter int LINE_CAP = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cle_pkg::cle_cmd_t cmd_i,
  input  logic              cmd_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              channel_o,
  output logic              last_o
);
  import cle_pkg::*;

  localparam int AW = $clog2(LINE_CAP);
  localparam int CW = $clog2(LINE_CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHR,
    S_SHL,
    S_HEAD,
    S_TAIL,
    S_MID,
    S_BACK
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   len_q, len_d, cur_q, cur_d;
  logic [CW-1:0]   idx_q, idx_d, end_q, end_d, tstart_q, tstart_d;
  logic [CW-1:0]   bs_q, bs_d, wpos_q, wpos_d;
  logic [7:0]      head_q, head_d, mid_q, mid_d;
  logic            head_wr_q, head_wr_d, has_mid_q, has_mid_d, tch_q, tch_d;
  logic            rd_ok_q, rd_ok_d;
  logic            out_valid_q, out_valid_d, out_chan_q, out_chan_d;
  logic            out_last_q, out_last_d;
  logic [7:0]      out_byte_q, out_byte_d;

  logic [7:0]      mem_q [LINE_CAP];
  logic [7:0]      rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  logic [CW-1:0]   idx_m1, idx_m2, idx_p1;
  logic            out_free, tail_empty;
  state_e          after_tail, after_head;

  assign idx_m1     = idx_q - CW'(1);
  assign idx_m2     = idx_q - CW'(2);
  assign idx_p1     = idx_q + CW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tail_empty = (tstart_q == end_q);
  assign after_tail = has_mid_q ? S_MID : ((bs_q != '0) ? S_BACK : S_IDLE);
  assign after_head = tail_empty ? after_tail : S_TAIL;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    end_d       = end_q;
    tstart_d    = tstart_q;
    bs_d        = bs_q;
    wpos_d      = wpos_q;
    head_d      = head_q;
    mid_d       = mid_q;
    head_wr_d   = head_wr_q;
    has_mid_d   = has_mid_q;
    tch_d       = tch_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_chan_d  = out_chan_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_INSERT: begin
              if (len_q < CW'(LINE_CAP - 1)) begin
                wpos_d    = cur_q;
                head_d    = cmd_i.key;
                head_wr_d = 1'b1;
                tstart_d  = cur_q + CW'(1);
                end_d     = len_q + CW'(1);
                bs_d      = len_q - cur_q;
                has_mid_d = 1'b0;
                tch_d     = 1'b0;
                idx_d     = len_q;
                len_d     = len_q + CW'(1);
                cur_d     = cur_q + CW'(1);
                state_d   = (len_q != cur_q) ? S_SHR : S_HEAD;
              end
            end
            OP_DELETE: begin
              if (cur_q != '0) begin
                head_d    = KEY_BS;
                head_wr_d = 1'b0;
                tstart_d  = cur_q - CW'(1);
                end_d     = len_q - CW'(1);
                has_mid_d = 1'b1;
                mid_d     = KEY_SPACE;
                bs_d      = len_q - cur_q + CW'(1);
                tch_d     = 1'b0;
                idx_d     = cur_q;
                len_d     = len_q - CW'(1);
                cur_d     = cur_q - CW'(1);
                state_d   = (cur_q != len_q) ? S_SHL : S_HEAD;
              end
            end
            OP_ENTER: begin
              head_d    = KEY_LF;
              head_wr_d = 1'b0;
              tstart_d  = '0;
              end_d     = len_q;
              has_mid_d = 1'b1;
              mid_d     = KEY_NUL;
              bs_d      = '0;
              tch_d     = 1'b1;
              len_d     = '0;
              cur_d     = '0;
              state_d   = S_HEAD;
            end
            OP_RIGHT: begin
              if (cur_q < len_q) begin
                tstart_d  = cur_q;
                end_d     = cur_q + CW'(1);
                idx_d     = cur_q;
                has_mid_d = 1'b0;
                bs_d      = '0;
                tch_d     = 1'b0;
                cur_d     = cur_q + CW'(1);
                state_d   = S_TAIL;
              end
            end
            OP_LEFT: begin
              if (cur_q != '0) begin
                head_d    = KEY_BS;
                head_wr_d = 1'b0;
                tstart_d  = '0;
                end_d     = '0;
                has_mid_d = 1'b0;
                bs_d      = '0;
                tch_d     = 1'b0;
                cur_d     = cur_q - CW'(1);
                state_d   = S_HEAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHR: begin
        if (!rd_ok_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1[AW-1:0];
          rd_ok_d   = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[AW-1:0];
          mem_wdata = rdata_q;
          idx_d     = idx_m1;
          if (idx_m1 > wpos_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_m2[AW-1:0];
          end else begin
            rd_ok_d = 1'b0;
            state_d = S_HEAD;
          end
        end
      end
      S_SHL: begin
        if (!rd_ok_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          rd_ok_d   = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_m1[AW-1:0];
          mem_wdata = rdata_q;
          idx_d     = idx_p1;
          if (idx_p1 <= end_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
          end else begin
            rd_ok_d = 1'b0;
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = head_q;
          out_chan_d  = 1'b0;
          out_last_d  = tail_empty && !has_mid_q && (bs_q == '0);
          if (head_wr_q) begin
            mem_we    = 1'b1;
            mem_waddr = wpos_q[AW-1:0];
            mem_wdata = head_q;
          end
          idx_d   = tstart_q;
          state_d = after_head;
        end
      end
      S_TAIL: begin
        if (!rd_ok_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          rd_ok_d   = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          out_chan_d  = tch_q;
          out_last_d  = (idx_p1 == end_q) && !has_mid_q && (bs_q == '0);
          idx_d       = idx_p1;
          if (idx_p1 != end_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
          end else begin
            rd_ok_d = 1'b0;
            state_d = after_tail;
          end
        end
      end
      S_MID: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = mid_q;
          out_chan_d  = tch_q;
          out_last_d  = (bs_q == '0);
          state_d     = (bs_q != '0) ? S_BACK : S_IDLE;
        end
      end
      S_BACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = KEY_BS;
          out_chan_d  = 1'b0;
          out_last_d  = (bs_q == CW'(1));
          bs_d        = bs_q - CW'(1);
          if (bs_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    end_q      <= end_d;
    tstart_q   <= tstart_d;
    bs_q       <= bs_d;
    wpos_q     <= wpos_d;
    head_q     <= head_d;
    mid_q      <= mid_d;
    head_wr_q  <= head_wr_d;
    has_mid_q  <= has_mid_d;
    tch_q      <= tch_d;
    out_byte_q <= out_byte_d;
    out_chan_q <= out_chan_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign channel_o   = out_chan_q;
  assign last_o      = out_last_q;

  a_cur_within_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond end of line");

  a_len_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(LINE_CAP - 1))
    else $error("line length exceeds capacity");

  a_idle_no_prefetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_ok_q)
    else $error("stale memory prefetch left in idle");

  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_last_q) |-> (state_q != S_IDLE))
    else $error("engine went idle before the final byte of a key");

endmodule
